### hw/rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the priority task scheduler
// Store geometry, item kinds, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package pts_pkg;
	localparam int QUEUE_DEPTH  = 16;
	localparam int TASK_ID_BITS = 8;
	localparam int IDX_W        = $clog2(QUEUE_DEPTH);
	localparam int FILL_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int CNT_W        = 10;
	localparam logic [CNT_W-1:0] TICK_MAX = CNT_W'(999);

	typedef enum logic [1:0] {
		KIND_ADD      = 2'd0,
		KIND_TICK     = 2'd1,
		KIND_DISPATCH = 2'd2,
		KIND_NONE     = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROMOTE,
		ST_POP,
		ST_RERUN,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;    // capture the item
		logic add;      // insert item task into ready store
		logic tick;     // count down the delay store
		logic promote;  // move delay head into ready store
		logic pop;      // pop ready head into the dispatch register
		logic rerun;    // reinsert the dispatched task
		logic report;   // strobe the result
	} pts_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic         delay_head_zero; // delay store nonempty, head count zero
		logic         ready_empty;
		logic         rerun_req;
		kind_t        kind;
	} pts_stat_t;
endpackage

### hw/rtl/priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// priority_task_scheduler: ready queue plus delay queue task scheduler
// Sorted ready store (by priority) and delay store (by remaining ticks).
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Every item yields one
// result, shown for a single cycle with done high; the receiver cannot stall
// it, so capture it on that cycle. An add or tick is one store operation;
// a dispatch first promotes each delayed task whose count is zero, then pops
// the ready head and reinserts it if it reruns. The sequencer does one store
// operation per cycle; each insert is a parallel compare-and-shift over the
// store, so cost does not grow with depth. Ties keep arrival order.
module priority_task_scheduler import pts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] kind,
	input  logic [7:0] task_id,
	input  logic [7:0] priority_req,
	input  logic       rerun_enable,
	input  logic [9:0] rerun_ticks,
	output logic       done,
	output logic       dispatched_valid,
	output logic [7:0] dispatched_task,
	output logic [7:0] dispatched_priority,
	output logic       all_done,
	output logic       overflow,
	output logic [4:0] ready_count,
	output logic [4:0] delayed_count
);
	pts_cmd_t  cmd;
	pts_stat_t stat;

	// sequencer: one item at a time
	pts_ctrl u_ctrl (
		.clk, .arst_n, .start, .busy, .stat, .cmd
	);

	// stores and result registers; done is the report command registered
	pts_dpath u_dpath (
		.clk, .arst_n, .cmd, .stat,
		.kind, .task_id, .priority_req, .rerun_enable, .rerun_ticks,
		.dispatched_valid, .dispatched_task, .dispatched_priority,
		.all_done, .overflow, .ready_count, .delayed_count, .done
	);
endmodule

### hw/rtl/pts_ctrl.sv
// ----------------------------------------------------------------------------
// pts_ctrl: scheduler sequencer
// Steps one item through its operations and issues datapath commands.
// ----------------------------------------------------------------------------
module pts_ctrl import pts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  pts_stat_t stat,
	output pts_cmd_t  cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = ST_PROMOTE;
				end
			end
			ST_PROMOTE: begin
				// one store operation per cycle
				case (stat.kind)
					KIND_ADD: begin
						cmd.add = 1'b1;
						state_d = ST_DONE;
					end
					KIND_TICK: begin
						cmd.tick = 1'b1;
						state_d  = ST_DONE;
					end
					KIND_DISPATCH: begin
						if (stat.delay_head_zero) cmd.promote = 1'b1;
						else                      state_d = ST_POP;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_POP: begin
				if (stat.ready_empty) begin
					state_d = ST_DONE;
				end else begin
					cmd.pop = 1'b1;
					state_d = stat.rerun_req ? ST_RERUN : ST_DONE;
				end
			end
			ST_RERUN: begin
				cmd.rerun = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				cmd.report = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

### hw/rtl/pts_dpath.sv
// ----------------------------------------------------------------------------
// pts_dpath: sorted stores and result registers
// Shift-register stores that insert in order with a per-entry compare.
// ----------------------------------------------------------------------------
module pts_dpath import pts_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pts_cmd_t                cmd,
	output pts_stat_t               stat,
	input  logic [1:0]              kind,
	input  logic [7:0]              task_id,
	input  logic [7:0]              priority_req,
	input  logic                    rerun_enable,
	input  logic [9:0]              rerun_ticks,
	output logic                    dispatched_valid,
	output logic [7:0]              dispatched_task,
	output logic [7:0]              dispatched_priority,
	output logic                    all_done,
	output logic                    overflow,
	output logic [4:0]              ready_count,
	output logic [4:0]              delayed_count,
	output logic                    done
);
	logic [TASK_ID_BITS-1:0] r_task_q [QUEUE_DEPTH];
	logic [7:0]              r_prio_q [QUEUE_DEPTH];
	logic [TASK_ID_BITS-1:0] d_task_q [QUEUE_DEPTH];
	logic [7:0]              d_prio_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]        d_cnt_q  [QUEUE_DEPTH];
	logic [FILL_W-1:0]       r_fill_q, d_fill_q;

	kind_t                   kind_q;
	logic [TASK_ID_BITS-1:0] id_q;
	logic [7:0]              prio_q;
	logic                    rerun_q;
	logic [CNT_W-1:0]        ticks_q;
	logic                    dval_q, ovf_q, done_q;
	logic [TASK_ID_BITS-1:0] dtask_q;
	logic [7:0]              dprio_q;

	// ready insert source
	logic                    r_ins;
	logic [TASK_ID_BITS-1:0] r_ins_task;
	logic [7:0]              r_ins_prio;
	logic                    r_full, d_full, d_ins;

	assign r_full = (r_fill_q == FILL_W'(QUEUE_DEPTH));
	assign d_full = (d_fill_q == FILL_W'(QUEUE_DEPTH));

	always_comb begin
		r_ins      = 1'b0;
		r_ins_task = id_q;
		r_ins_prio = prio_q;
		d_ins      = 1'b0;
		if (cmd.add) r_ins = 1'b1;
		if (cmd.promote) begin
			r_ins      = 1'b1;
			r_ins_task = d_task_q[0];
			r_ins_prio = d_prio_q[0];
		end
		if (cmd.rerun) begin
			r_ins_task = dtask_q;
			r_ins_prio = dprio_q;
			if (ticks_q == '0) r_ins = 1'b1;
			else               d_ins = 1'b1;
		end
	end

	// ready store: on pop entry k takes neighbor k+1; on insert it takes new item, its own, or neighbor k-1
	logic [QUEUE_DEPTH-1:0] r_gt;
	always_comb begin
		for (int k = 0; k < QUEUE_DEPTH; k++)
			r_gt[k] = (FILL_W'(k) < r_fill_q) && (r_prio_q[k] > r_ins_prio);
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			if (cmd.pop) begin
				if (k < QUEUE_DEPTH - 1) begin
					r_task_q[k] <= r_task_q[k+1];
					r_prio_q[k] <= r_prio_q[k+1];
				end
			end else if (r_ins && !r_full) begin
				if (r_gt[k] || FILL_W'(k) == r_fill_q) begin
					if (k == 0 || !r_gt[k-1 < 0 ? 0 : k-1] || FILL_W'(k) == 0) begin
						r_task_q[k] <= r_ins_task;
						r_prio_q[k] <= r_ins_prio;
					end else begin
						r_task_q[k] <= r_task_q[k-1 < 0 ? 0 : k-1];
						r_prio_q[k] <= r_prio_q[k-1 < 0 ? 0 : k-1];
					end
				end
			end
		end
	end

	// delay store
	logic [QUEUE_DEPTH-1:0] d_gt;
	always_comb begin
		for (int k = 0; k < QUEUE_DEPTH; k++)
			d_gt[k] = (FILL_W'(k) < d_fill_q) && (d_cnt_q[k] > ticks_q);
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			if (cmd.promote) begin
				if (k < QUEUE_DEPTH - 1) begin
					d_task_q[k] <= d_task_q[k+1];
					d_prio_q[k] <= d_prio_q[k+1];
					d_cnt_q[k]  <= d_cnt_q[k+1];
				end
			end else if (cmd.tick) begin
				if (d_cnt_q[k] != '0) d_cnt_q[k] <= d_cnt_q[k] - CNT_W'(1);
			end else if (d_ins && !d_full) begin
				if (d_gt[k] || FILL_W'(k) == d_fill_q) begin
					if (k == 0 || !d_gt[k-1 < 0 ? 0 : k-1]) begin
						d_task_q[k] <= dtask_q;
						d_prio_q[k] <= dprio_q;
						d_cnt_q[k]  <= ticks_q;
					end else begin
						d_task_q[k] <= d_task_q[k-1 < 0 ? 0 : k-1];
						d_prio_q[k] <= d_prio_q[k-1 < 0 ? 0 : k-1];
						d_cnt_q[k]  <= d_cnt_q[k-1 < 0 ? 0 : k-1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q  <= kind_t'(kind);
			id_q    <= task_id[TASK_ID_BITS-1:0];
			prio_q  <= priority_req;
			rerun_q <= rerun_enable;
			ticks_q <= (rerun_ticks > TICK_MAX) ? TICK_MAX : rerun_ticks;
		end
		if (cmd.pop) begin
			dtask_q <= r_task_q[0];
			dprio_q <= r_prio_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_fill_q <= '0;
			d_fill_q <= '0;
			dval_q   <= 1'b0;
			ovf_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.report;
			if (cmd.latch) begin
				dval_q <= 1'b0;
				ovf_q  <= 1'b0;
			end
			if (cmd.pop) begin
				dval_q   <= 1'b1;
				r_fill_q <= r_fill_q - FILL_W'(1);
			end
			if (cmd.promote) d_fill_q <= d_fill_q - FILL_W'(1);
			if (r_ins) begin
				if (r_full) ovf_q <= 1'b1;
				else        r_fill_q <= r_fill_q + FILL_W'(1);
			end
			if (d_ins) begin
				if (d_full) ovf_q <= 1'b1;
				else        d_fill_q <= d_fill_q + FILL_W'(1);
			end
		end
	end

	assign stat.delay_head_zero = (d_fill_q != '0) && (d_cnt_q[0] == '0);
	assign stat.ready_empty     = (r_fill_q == '0);
	assign stat.rerun_req       = rerun_q;
	assign stat.kind            = kind_q;

	assign done                = done_q;
	assign dispatched_valid    = dval_q;
	assign dispatched_task     = dval_q ? 8'(dtask_q) : 8'd0;
	assign dispatched_priority = dval_q ? dprio_q : 8'd0;
	assign all_done            = (r_fill_q == '0) && (d_fill_q == '0);
	assign overflow            = ovf_q;
	assign ready_count         = 5'(r_fill_q);
	assign delayed_count       = 5'(d_fill_q);
endmodule

### tb/pts_checker.sv
// ----------------------------------------------------------------------------
// pts_checker: scoreboard for the priority task scheduler
// Predicts the result of every accepted item and compares it with the strobed result.
// ----------------------------------------------------------------------------
module pts_checker import pts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [1:0] kind,
	input  logic [7:0] task_id,
	input  logic [7:0] priority_req,
	input  logic       rerun_enable,
	input  logic [9:0] rerun_ticks,
	input  logic       done,
	input  logic       dispatched_valid,
	input  logic [7:0] dispatched_task,
	input  logic [7:0] dispatched_priority,
	input  logic       all_done,
	input  logic       overflow,
	input  logic [4:0] ready_count,
	input  logic [4:0] delayed_count,
	output int         mismatches,
	output int         pending
);
	typedef struct {
		logic [7:0]       id;
		logic [7:0]       prio;
		logic [CNT_W-1:0] cnt;
	} sched_entry_t;

	typedef struct packed {
		logic       dvalid;
		logic [7:0] dtask;
		logic [7:0] dprio;
		logic       empty;
		logic       ovf;
		logic [4:0] rcnt;
		logic [4:0] dcnt;
	} sched_status_t;

	sched_entry_t  ready_q [QUEUE_DEPTH];
	sched_entry_t  delay_q [QUEUE_DEPTH];
	int            ready_n, delay_n;
	sched_status_t expected_status [$];

	// sorted insert behind equal keys; 0 when the store is full
	function automatic bit ready_push(logic [7:0] id, logic [7:0] prio);
		int pos;
		if (ready_n >= QUEUE_DEPTH) return 0;
		pos = 0;
		while (pos < ready_n && ready_q[pos].prio <= prio) pos++;
		for (int k = ready_n; k > pos; k--) ready_q[k] = ready_q[k-1];
		ready_q[pos] = '{id, prio, '0};
		ready_n++;
		return 1;
	endfunction

	function automatic bit delay_push(logic [7:0] id, logic [7:0] prio, logic [CNT_W-1:0] cnt);
		int pos;
		if (delay_n >= QUEUE_DEPTH) return 0;
		pos = 0;
		while (pos < delay_n && delay_q[pos].cnt <= cnt) pos++;
		for (int k = delay_n; k > pos; k--) delay_q[k] = delay_q[k-1];
		delay_q[pos] = '{id, prio, cnt};
		delay_n++;
		return 1;
	endfunction

	function automatic sched_status_t schedule_item(kind_t k, logic [7:0] id, logic [7:0] prio,
			logic rerun, logic [CNT_W-1:0] ticks);
		sched_status_t s;
		sched_entry_t  head;
		s = '0;
		case (k)
			KIND_ADD: begin
				if (!ready_push(id, prio)) s.ovf = 1;
			end
			KIND_TICK: begin
				for (int i = 0; i < delay_n; i++)
					if (delay_q[i].cnt != 0) delay_q[i].cnt--;
			end
			KIND_DISPATCH: begin
				// expired delay heads go back to ready first; lost if ready is full
				while (delay_n > 0 && delay_q[0].cnt == 0) begin
					head = delay_q[0];
					for (int i = 1; i < delay_n; i++) delay_q[i-1] = delay_q[i];
					delay_n--;
					if (!ready_push(head.id, head.prio)) s.ovf = 1;
				end
				if (ready_n > 0) begin
					s.dvalid = 1;
					s.dtask  = ready_q[0].id;
					s.dprio  = ready_q[0].prio;
					for (int i = 1; i < ready_n; i++) ready_q[i-1] = ready_q[i];
					ready_n--;
					if (rerun) begin
						if (ticks > TICK_MAX) ticks = TICK_MAX;
						if (ticks == 0) begin
							if (!ready_push(s.dtask, s.dprio)) s.ovf = 1;
						end else if (!delay_push(s.dtask, s.dprio, ticks)) begin
							s.ovf = 1;
						end
					end
				end
			end
			default: ;
		endcase
		s.empty = (ready_n == 0 && delay_n == 0);
		s.rcnt  = 5'(ready_n);
		s.dcnt  = 5'(delay_n);
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sched_status_t got, want;
		if (!arst_n) begin
			ready_n = 0;
			delay_n = 0;
			expected_status.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (done) begin
				got = '{dispatched_valid, dispatched_task, dispatched_priority,
					all_done, overflow, ready_count, delayed_count};
				if (expected_status.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result with nothing expected: %p", got);
				end else begin
					want = expected_status.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p, got %p", want, got);
					end
				end
			end
			if (start && !busy)
				expected_status.push_back(schedule_item(kind_t'(kind), task_id,
					priority_req, rerun_enable, rerun_ticks));
			pending = expected_status.size();
		end
	end
endmodule

### tb/priority_task_scheduler_tb.sv
// ----------------------------------------------------------------------------
// priority_task_scheduler_tb: top of the scheduler testbench
// Directed corner items then random bursts of adds, ticks, dispatches and unused
// kinds, checked item by item against a behavioral scoreboard.
// ----------------------------------------------------------------------------
module priority_task_scheduler_tb;
	import pts_pkg::*;

	localparam int ITEM_COUNT  = 1600;
	localparam int CYCLE_LIMIT = 600000;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       start = 0;
	logic       busy;
	logic [1:0] kind = KIND_NONE;
	logic [7:0] task_id = 0;
	logic [7:0] priority_req = 0;
	logic       rerun_enable = 0;
	logic [9:0] rerun_ticks = 0;
	logic       done, dispatched_valid, all_done, overflow;
	logic [7:0] dispatched_task, dispatched_priority;
	logic [4:0] ready_count, delayed_count;
	int         mismatches, pending;
	int         cycles = 0;

	always #5 clk = ~clk;

	priority_task_scheduler uut (.*);
	pts_checker scoreboard (.*);

	// hard stop in case the handshake hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("priority_task_scheduler verification failed");
			$finish;
		end
	end

	// drive one item at the falling edge and hold it until accepted
	task automatic issue(kind_t k, logic [7:0] id, logic [7:0] prio, logic rr, logic [9:0] tk);
		kind         = k;
		task_id      = id;
		priority_req = prio;
		rerun_enable = rr;
		rerun_ticks  = tk;
		start        = 1;
		do @(posedge clk); while (busy);
		@(negedge clk);
		start = 0;
	endtask

	task automatic idle(int n);
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		int add_pct, burst, r;
		logic [7:0] prio;
		logic [9:0] tk;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// empty-store dispatch, unused kind, id/priority extremes
		issue(KIND_DISPATCH, 8'hFF, 8'hFF, 1, 10'd5);
		issue(KIND_NONE, 8'hAA, 8'h55, 1, 10'h3FF);
		issue(KIND_ADD, 8'h00, 8'hFF, 0, 0);
		issue(KIND_ADD, 8'hFF, 8'h00, 0, 0);
		// fill the ready store past full, with ties, to hit overflow
		for (int i = 0; i < 15; i++) issue(KIND_ADD, 8'(i + 16), 8'(i % 3), 0, 0);
		issue(KIND_DISPATCH, 0, 0, 1, 10'd0);
		// rerun with a count above the saturation point and a short one
		issue(KIND_DISPATCH, 0, 0, 1, 10'd1023);
		issue(KIND_DISPATCH, 0, 0, 1, 10'd1);
		issue(KIND_TICK, 0, 0, 0, 0);
		issue(KIND_DISPATCH, 0, 0, 0, 0);
		drain();

		add_pct = 40;
		for (int n = 0; n < ITEM_COUNT; ) begin
			// change mix now and then so stores both fill and drain empty
			if (n % 200 < 30 && $urandom_range(0, 29) == 0) begin
				r = $urandom_range(0, 2);
				add_pct = (r == 0) ? 10 : (r == 1) ? 35 : 65;
			end
			burst = $urandom_range(1, 30);
			for (int b = 0; b < burst && n < ITEM_COUNT; b++, n++) begin
				r    = $urandom_range(0, 99);
				prio = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
				case ($urandom_range(0, 9))
					0, 1, 2: tk = 0;
					3:       tk = 10'($urandom);
					default: tk = 10'($urandom_range(1, 4));
				endcase
				if (r < add_pct)
					issue(KIND_ADD, 8'($urandom), prio, 1'($urandom), tk);
				else if (r < add_pct + 20)
					issue(KIND_TICK, 8'($urandom), prio, 1'($urandom), tk);
				else if (r < 98)
					issue(KIND_DISPATCH, 8'($urandom), prio,
						$urandom_range(0, 9) < 7, tk);
				else
					issue(KIND_NONE, 8'($urandom), prio, 1'($urandom), tk);
			end
			if ($urandom_range(0, 15) == 0) drain();
			else if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 12));
		end

		drain();
		idle(20);
		if (mismatches == 0 && pending == 0)
			$display("priority_task_scheduler verification clean");
		else
			$display("priority_task_scheduler verification failed");
		$finish;
	end
endmodule
